// ----- src/swa_pkg.sv -----
// shared constants and control types for the sliding window average block
`default_nettype none
package swa_pkg;

  localparam int CFG_BITS = 7;
  localparam int DEF_MAX_WINDOW = 64;
  localparam int DEF_SAMPLE_BITS = 16;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_item;
    logic prep;
    logic update;
    logic div_init;
    logic div_step;
    logic out_load;
  } swa_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic result_due;
    logic out_busy;
  } swa_stat_t;

endpackage
`default_nettype wire

// ----- src/swa_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none
module swa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- src/swa_ctrl.sv -----
// controller state machine: sequences one item through window update and, when a result is due, division
`default_nettype none
module swa_ctrl #(
  parameter int SUM_BITS = 23
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire swa_pkg::swa_stat_t stat,
  output swa_pkg::swa_cmd_t     cmd
);
  import swa_pkg::*;

  localparam int CNT_BITS = (SUM_BITS > 1) ? $clog2(SUM_BITS) : 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_UPDATE,
    ST_DIV_INIT,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t state;
  state_t state_next;
  logic [CNT_BITS-1:0] step_cnt;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load_item = 1'b1;
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = stat.result_due ? ST_DIV_INIT : ST_IDLE;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step_cnt == '0) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_DIV_INIT) begin
        step_cnt <= CNT_BITS'(SUM_BITS - 1);
      end else if (state == ST_DIV && step_cnt != '0) begin
        step_cnt <= step_cnt - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/swa_dp.sv -----
// datapath: window ram, running sum, fill count, serial divider and output register
`default_nettype none
module swa_dp #(
  parameter int MAX_WINDOW = swa_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = swa_pkg::DEF_SAMPLE_BITS,
  parameter int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [swa_pkg::CFG_BITS-1:0]  cfg_data,
  input  wire logic [SAMPLE_BITS-1:0]        sample,
  input  wire logic                          start_of_array,
  input  wire logic                          m_tready,
  output logic                               m_tvalid,
  output logic      [SAMPLE_BITS-1:0]        average,
  input  wire swa_pkg::swa_cmd_t             cmd,
  output swa_pkg::swa_stat_t                 stat
);
  import swa_pkg::*;

  localparam int SLOT_BITS = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  logic [CFG_BITS-1:0] win_size;
  logic [CFG_BITS-1:0] w_eff;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic start_q;
  logic signed [SUM_BITS-1:0] sum;
  logic [CFG_BITS-1:0] fill;
  logic [SLOT_BITS-1:0] slot;
  logic full_q;

  logic [SLOT_BITS-1:0] slot_eff;
  logic [CFG_BITS-1:0] fill_eff;
  logic [CFG_BITS-1:0] fill_inc;
  logic signed [SUM_BITS-1:0] old_val;
  logic signed [SAMPLE_BITS-1:0] rdata;

  logic neg_q;
  logic [CFG_BITS-1:0] rem;
  logic [SUM_BITS-1:0] quot;
  logic [CFG_BITS:0] trial;

  // size zero acts as one, sizes above the ram depth clamp to it
  always_comb begin
    if (win_size == '0) begin
      w_eff = CFG_BITS'(1);
    end else if (32'(win_size) > MAX_WINDOW) begin
      w_eff = CFG_BITS'(MAX_WINDOW);
    end else begin
      w_eff = win_size;
    end
  end

  always_comb begin
    if (start_q || 32'(slot) >= 32'(w_eff)) begin
      slot_eff = '0;
    end else begin
      slot_eff = slot;
    end
    if (start_q) begin
      fill_eff = '0;
    end else if (fill > w_eff) begin
      fill_eff = w_eff;
    end else begin
      fill_eff = fill;
    end
    fill_inc = fill + 1'b1;
    old_val = full_q ? SUM_BITS'(rdata) : '0;
    trial = {rem, quot[SUM_BITS-1]} - {1'b0, w_eff};
  end

  // valid in the update cycle: a result follows once the window is full
  assign stat.result_due = full_q || (fill_inc == w_eff);
  assign stat.out_busy = m_tvalid && !m_tready;

  swa_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(MAX_WINDOW),
    .ADDR_BITS(SLOT_BITS)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.update),
    .waddr(slot),
    .wdata(sample_q),
    .re   (cmd.prep),
    .raddr(slot_eff),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      win_size <= CFG_BITS'(1);
      sum <= '0;
      fill <= '0;
      slot <= '0;
      full_q <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        win_size <= cfg_data;
        sum <= '0;
        fill <= '0;
        slot <= '0;
      end else if (cmd.prep) begin
        sum <= start_q ? '0 : sum;
        fill <= fill_eff;
        slot <= slot_eff;
        full_q <= (fill_eff == w_eff);
      end else if (cmd.update) begin
        // oldest sample leaves before the new one joins
        sum <= sum - old_val + SUM_BITS'(sample_q);
        fill <= full_q ? fill : fill_inc;
        if (32'(slot) + 1 == 32'(w_eff)) begin
          slot <= '0;
        end else begin
          slot <= slot + 1'b1;
        end
      end
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      sample_q <= sample;
      start_q <= start_of_array;
    end
    if (cmd.div_init) begin
      neg_q <= sum[SUM_BITS-1];
      quot <= sum[SUM_BITS-1] ? SUM_BITS'(-sum) : SUM_BITS'(sum);
      rem <= '0;
    end else if (cmd.div_step) begin
      // restoring division on the magnitude, one quotient bit per cycle
      if (!trial[CFG_BITS]) begin
        rem <= trial[CFG_BITS-1:0];
        quot <= {quot[SUM_BITS-2:0], 1'b1};
      end else begin
        rem <= {rem[CFG_BITS-2:0], quot[SUM_BITS-1]};
        quot <= {quot[SUM_BITS-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      average <= neg_q ? SAMPLE_BITS'(-quot) : SAMPLE_BITS'(quot);
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_tvalid || m_tready))
    else $error("pending result overwritten");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> (fill <= w_eff))
    else $error("fill count above window size");

  a_slot_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.update |=> (32'(slot) < 32'(w_eff)))
    else $error("write slot outside window");

  a_div_after_update: assert property (@(posedge clk) disable iff (rst)
    cmd.div_init |-> $past(cmd.update))
    else $error("division started without a window update");

endmodule
`default_nettype wire

// ----- src/sliding_window_average.sv -----
// Moving average over the last window_size signed samples (1 to MAX_WINDOW, size 0 acts
// as 1). Each sample is one transfer on the s_ side; once the window is full every sample
// gives one average on the m_ side (sum over window / size, truncated toward zero), before
// that no result. s_tuser high clears the window before its sample; writing the size
// register also clears it. An item with no result passes through the prepare and update
// states; one with a result then goes through the bit-serial divider, which produces one
// quotient bit per cycle, and waits in the output state until the output register frees
// up. A finished average waits in the output register while the next sample is taken.
`default_nettype none
module sliding_window_average #(
  parameter int MAX_WINDOW = swa_pkg::DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS = swa_pkg::DEF_SAMPLE_BITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [swa_pkg::CFG_BITS-1:0]        cfg_data,   // window_size
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,    // sample
  input  wire logic                                s_tuser,    // start_of_array
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic      [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata     // average
);
  import swa_pkg::*;

  localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW) + 1;
  localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

  swa_cmd_t cmd;
  swa_stat_t stat;
  logic [SAMPLE_BITS-1:0] average;

  assign m_tdata = DATA_BITS'(average);

  swa_ctrl #(
    .SUM_BITS(SUM_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  swa_dp #(
    .MAX_WINDOW (MAX_WINDOW),
    .SAMPLE_BITS(SAMPLE_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .sample        (s_tdata[SAMPLE_BITS-1:0]),
    .start_of_array(s_tuser),
    .m_tready      (m_tready),
    .m_tvalid      (m_tvalid),
    .average       (average),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule
`default_nettype wire
